// File: design/scdb_pkg.sv
// ----------------------------------------------------------------------------
// scdb_pkg
// Shared types, codes and constants of the SCSI target CDB decoder.
// ----------------------------------------------------------------------------
package scdb_pkg;

  localparam int CDB_BYTES_DEF   = 10;
  localparam int INQUIRY_MAX_DEF = 36;
  localparam int IDX_W           = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  localparam logic [2:0] ACT_STATUS   = 3'd0;
  localparam logic [2:0] ACT_SENSE    = 3'd1;
  localparam logic [2:0] ACT_INQUIRY  = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_WRITE    = 3'd4;
  localparam logic [2:0] ACT_REJECTED = 3'd5;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
  localparam logic [7:0] OP_FORMAT_UNIT     = 8'h04;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_WRITE6          = 8'h0a;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_MODE_SELECT     = 8'h15;
  localparam logic [7:0] OP_MODE_SENSE      = 8'h1a;
  localparam logic [7:0] OP_START_STOP      = 8'h1b;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2a;
  localparam logic [7:0] OP_VERIFY10        = 8'h2f;
  localparam logic [7:0] OP_READ_BUFFER     = 8'h3c;

  localparam logic [7:0] STS_GOOD        = 8'd0;
  localparam logic [7:0] STS_FAIL        = 8'd1;
  localparam logic [7:0] STS_READ_BUFFER = 8'd6;
  localparam logic [7:0] STS_VERIFY      = 8'd10;

  localparam logic [5:0]  SENSE_LEN    = 6'd13;
  localparam logic [15:0] COUNT6_ZERO  = 16'd256;
  localparam logic [4:0]  LBA6_HI_MASK = 5'h1f;

  localparam logic [0:0] REG_TARGET_ID = 1'b0;
  localparam logic [0:0] REG_MEDIUM    = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [2:0]  action;
    logic [31:0] lba;
    logic [15:0] block_count;
    logic [5:0]  transfer_length;
    logic [7:0]  status_byte;
  } out_item_t;

  // completed or rejected CDB, bytes 1..8 as collected
  typedef struct packed {
    logic            rejected;
    logic [7:0]      opcode;
    logic [7:0][7:0] arg;
  } cdb_req_t;

endpackage

// File: design/scsi_target_cdb_decoder_unit.sv
// ----------------------------------------------------------------------------
// scsi_target_cdb_decoder_unit
// Target-side SCSI command phase decoder for 6- and 10-byte CDBs.
// ----------------------------------------------------------------------------
// Takes one event per cycle (selection, command byte, bus reset) while full is
// low. The final CDB byte, or a rejected first byte, produces one result,
// which passes through the two-entry request queue and then the decoder's
// output register. full rises only while two decoded requests wait behind an
// unread result, so sustained rate is one event per cycle when results are
// drained.
module scsi_target_cdb_decoder_unit #(
  parameter int CDB_BYTES   = scdb_pkg::CDB_BYTES_DEF,
  parameter int INQUIRY_MAX = scdb_pkg::INQUIRY_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  scdb_pkg::in_item_t                in_item,
  output logic                              empty,
  input  logic                              pop,
  output scdb_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scdb_pkg::CFG_AW-1:0]       paddr,
  input  logic [scdb_pkg::CFG_DW-1:0]       pwdata,
  output logic [scdb_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);
  import scdb_pkg::*;

  logic [0:0] reg_sel;
  logic [2:0] tid_r;
  logic       medium_r;
  logic       cfg_wr;
  logic       accept;
  logic       fr_valid;
  cdb_req_t   fr_req;
  logic       q_valid, q_full, q_pop;
  cdb_req_t   q_req;
  logic       out_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_TARGET_ID) ? {{(CFG_DW-3){1'b0}}, tid_r}
                                              : {{(CFG_DW-1){1'b0}}, medium_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_r    <= 3'd6;
      medium_r <= 1'b0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_TARGET_ID) begin
        tid_r <= pwdata[2:0];
      end else if (reg_sel == REG_MEDIUM) begin
        medium_r <= pwdata[0];
      end
    end
  end

  assign full   = q_full;
  assign accept = push && !full;
  assign empty  = !out_valid;

  scdb_front #(
    .CDB_BYTES(CDB_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .target_id(tid_r),
    .req_valid(fr_valid),
    .req      (fr_req)
  );

  scdb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid),
    .wr_req  (fr_req),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_req  (q_req),
    .full    (q_full)
  );

  scdb_back #(
    .INQUIRY_MAX(INQUIRY_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (q_valid),
    .req           (q_req),
    .req_pop       (q_pop),
    .medium_present(medium_r),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .out_pop       (pop)
  );

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(fr_valid && q_full))
    else $error("request written into a full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !q_valid) |=> empty)
    else $error("result still shown after last request was taken");

endmodule

// File: design/scdb_front.sv
// ----------------------------------------------------------------------------
// scdb_front
// Takes events, tracks selection and collects CDB bytes into a request.
// ----------------------------------------------------------------------------
module scdb_front #(
  parameter int CDB_BYTES = scdb_pkg::CDB_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  scdb_pkg::in_item_t item,
  input  logic [2:0]         target_id,
  output logic               req_valid,
  output scdb_pkg::cdb_req_t req
);
  import scdb_pkg::*;

  localparam int SW = $clog2(CDB_BYTES);

  logic                 selected_r, selected_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     exp_r, exp_nxt;
  logic [7:0]           store_r [CDB_BYTES];
  logic [IDX_W-1:0]     len;
  logic [IDX_W-1:0]     exp_eff;
  logic [IDX_W-1:0]     idx_inc;
  logic                 wr_store;

  function automatic logic [IDX_W-1:0] cdb_length(input logic [7:0] op);
    logic [IDX_W-1:0] l;
    case (op)
      OP_TEST_UNIT_READY, OP_REQUEST_SENSE, OP_FORMAT_UNIT, OP_READ6, OP_WRITE6,
      OP_INQUIRY, OP_MODE_SELECT, OP_MODE_SENSE, OP_START_STOP,
      OP_READ_BUFFER: l = IDX_W'(6);
      OP_READ_CAPACITY, OP_READ10, OP_WRITE10, OP_VERIFY10: l = IDX_W'(10);
      default: l = '0;
    endcase
    return l;
  endfunction

  assign len     = cdb_length(item.data);
  assign exp_eff = (idx_r == '0) ? len : exp_r;
  assign idx_inc = idx_r + IDX_W'(1);

  always_comb begin
    selected_nxt = selected_r;
    idx_nxt      = idx_r;
    exp_nxt      = exp_r;
    wr_store     = 1'b0;
    req_valid    = 1'b0;
    req.rejected = 1'b0;
    req.opcode   = store_r[0];
    for (int k = 0; k < 8; k++) begin
      req.arg[k] = store_r[k+1];
    end
    if (accept) begin
      case (item.cmd)
        CMD_RESET: begin
          selected_nxt = 1'b0;
          idx_nxt      = '0;
          exp_nxt      = IDX_W'(1);
        end
        CMD_SELECT: begin
          if (item.data[target_id]) begin
            selected_nxt = 1'b1;
            idx_nxt      = '0;
            exp_nxt      = IDX_W'(1);
          end
        end
        CMD_BYTE: begin
          if (selected_r) begin
            wr_store = idx_r < IDX_W'(CDB_BYTES);
            if (idx_r == '0 && len == '0) begin
              req_valid    = 1'b1;
              req.rejected = 1'b1;
              req.opcode   = item.data;
              selected_nxt = 1'b0;
              idx_nxt      = '0;
              exp_nxt      = IDX_W'(1);
            end else if (idx_inc >= exp_eff) begin
              req_valid    = 1'b1;
              selected_nxt = 1'b0;
              idx_nxt      = '0;
              exp_nxt      = IDX_W'(1);
            end else begin
              idx_nxt = idx_inc;
              exp_nxt = exp_eff;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selected_r <= 1'b0;
      idx_r      <= '0;
      exp_r      <= IDX_W'(1);
    end else begin
      selected_r <= selected_nxt;
      idx_r      <= idx_nxt;
      exp_r      <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_store) begin
      store_r[idx_r[SW-1:0]] <= item.data;
    end
  end

endmodule

// File: design/scdb_queue.sv
// ----------------------------------------------------------------------------
// scdb_queue
// Short request queue between the collector and the decoder.
// ----------------------------------------------------------------------------
module scdb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  scdb_pkg::cdb_req_t wr_req,
  input  logic               rd_en,
  output logic               rd_valid,
  output scdb_pkg::cdb_req_t rd_req,
  output logic               full
);
  import scdb_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cdb_req_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign rd_valid = cnt_r != '0;
  assign full     = cnt_r == CW'(QUEUE_DEPTH);
  assign rd_req   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_req;
    end
  end

endmodule

// File: design/scdb_back.sv
// ----------------------------------------------------------------------------
// scdb_back
// Decodes a collected CDB into a result and holds it in the output register.
// ----------------------------------------------------------------------------
module scdb_back #(
  parameter int INQUIRY_MAX = scdb_pkg::INQUIRY_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  scdb_pkg::cdb_req_t  req,
  output logic                req_pop,
  input  logic                medium_present,
  output logic                out_valid,
  output scdb_pkg::out_item_t out_item,
  input  logic                out_pop
);
  import scdb_pkg::*;

  localparam logic [7:0] INQ_MAX_B = 8'(INQUIRY_MAX);

  logic      valid_r;
  out_item_t item_r, res;
  logic [7:0] inq_len;
  logic [7:0] io_status;

  assign req_pop   = req_valid && (!valid_r || out_pop);
  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign inq_len   = (req.arg[3] > INQ_MAX_B) ? INQ_MAX_B : req.arg[3];
  assign io_status = medium_present ? STS_GOOD : STS_FAIL;

  always_comb begin
    res.opcode          = req.opcode;
    res.action          = ACT_STATUS;
    res.lba             = '0;
    res.block_count     = '0;
    res.transfer_length = '0;
    res.status_byte     = STS_FAIL;
    if (req.rejected) begin
      res.action = ACT_REJECTED;
    end else begin
      case (req.opcode)
        OP_TEST_UNIT_READY: begin
          res.status_byte = STS_GOOD;
        end
        OP_REQUEST_SENSE: begin
          res.action          = ACT_SENSE;
          res.transfer_length = SENSE_LEN;
          res.status_byte     = STS_GOOD;
        end
        OP_READ6, OP_WRITE6: begin
          res.action      = (req.opcode == OP_READ6) ? ACT_READ : ACT_WRITE;
          res.lba         = {11'd0, req.arg[0][4:0] & LBA6_HI_MASK, req.arg[1], req.arg[2]};
          res.block_count = (req.arg[3] == 8'd0) ? COUNT6_ZERO : {8'd0, req.arg[3]};
          res.status_byte = io_status;
        end
        OP_INQUIRY: begin
          res.action          = ACT_INQUIRY;
          res.transfer_length = inq_len[5:0];
          res.status_byte     = STS_GOOD;
        end
        OP_READ10, OP_WRITE10: begin
          res.action      = (req.opcode == OP_READ10) ? ACT_READ : ACT_WRITE;
          res.lba         = {req.arg[1], req.arg[2], req.arg[3], req.arg[4]};
          res.block_count = {req.arg[6], req.arg[7]};
          res.status_byte = io_status;
        end
        OP_VERIFY10: begin
          res.status_byte = STS_VERIFY;
        end
        OP_READ_BUFFER: begin
          res.status_byte = STS_READ_BUFFER;
        end
        default: begin
          res.status_byte = STS_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      item_r <= res;
    end
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the SCSI target CDB decoder against a predictor of its own. Each
// accepted request is decoded by the scoreboard; each popped result is
// compared field by field with the oldest prediction. A short directed set
// is followed by random CDB sequences under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import scdb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT       = 400000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 160;

  class cdb_scoreboard;
    logic [2:0]  target_id;
    logic        medium_present;
    bit          armed;
    int unsigned idx;
    int unsigned cdb_len;
    logic [7:0]  cdb [CDB_BYTES_DEF];
    out_item_t   pending [$];
    int unsigned errors;
    int unsigned mismatches;
    int unsigned checked;

    function new();
      target_id      = 3'd6;
      medium_present = 1'b0;
      clear();
    endfunction

    function void clear();
      armed   = 1'b0;
      idx     = 0;
      cdb_len = 1;
    endfunction

    static function int unsigned len_of(logic [7:0] op);
      case (op)
        OP_TEST_UNIT_READY, OP_REQUEST_SENSE, OP_FORMAT_UNIT, OP_READ6, OP_WRITE6,
        OP_INQUIRY, OP_MODE_SELECT, OP_MODE_SENSE, OP_START_STOP,
        OP_READ_BUFFER: return 6;
        OP_READ_CAPACITY, OP_READ10, OP_WRITE10, OP_VERIFY10: return 10;
        default: return 0;
      endcase
    endfunction

    function void note_request(in_item_t req);
      out_item_t want;
      want = '0;
      case (req.cmd)
        CMD_RESET: clear();
        CMD_SELECT: begin
          if (req.data[target_id]) begin
            armed   = 1'b1;
            idx     = 0;
            cdb_len = 1;
          end
        end
        CMD_BYTE: begin
          if (!armed) return;
          if (idx < CDB_BYTES_DEF) cdb[idx] = req.data;
          if (idx == 0) begin
            cdb_len = len_of(req.data);
            if (cdb_len == 0) begin
              want.opcode      = req.data;
              want.action      = ACT_REJECTED;
              want.status_byte = STS_FAIL;
              pending.push_back(want);
              clear();
              return;
            end
          end
          idx = (idx + 1) & 4'hf;
          if (idx < cdb_len) return;
          want.opcode      = cdb[0];
          want.action      = ACT_STATUS;
          want.status_byte = STS_FAIL;
          case (cdb[0])
            OP_TEST_UNIT_READY: want.status_byte = STS_GOOD;
            OP_REQUEST_SENSE: begin
              want.action          = ACT_SENSE;
              want.transfer_length = SENSE_LEN;
              want.status_byte     = STS_GOOD;
            end
            OP_READ6, OP_WRITE6: begin
              want.action      = (cdb[0] == OP_READ6) ? ACT_READ : ACT_WRITE;
              want.lba         = {11'd0, cdb[1][4:0] & LBA6_HI_MASK, cdb[2], cdb[3]};
              want.block_count = (cdb[4] == 8'd0) ? COUNT6_ZERO : {8'd0, cdb[4]};
              want.status_byte = medium_present ? STS_GOOD : STS_FAIL;
            end
            OP_INQUIRY: begin
              want.action          = ACT_INQUIRY;
              want.transfer_length = (cdb[4] > INQUIRY_MAX_DEF) ?
                                     6'(INQUIRY_MAX_DEF) : cdb[4][5:0];
              want.status_byte     = STS_GOOD;
            end
            OP_READ10, OP_WRITE10: begin
              want.action      = (cdb[0] == OP_READ10) ? ACT_READ : ACT_WRITE;
              want.lba         = {cdb[2], cdb[3], cdb[4], cdb[5]};
              want.block_count = {cdb[7], cdb[8]};
              want.status_byte = medium_present ? STS_GOOD : STS_FAIL;
            end
            OP_VERIFY10:    want.status_byte = STS_VERIFY;
            OP_READ_BUFFER: want.status_byte = STS_READ_BUFFER;
            default: ;
          endcase
          pending.push_back(want);
          clear();
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result: op %h action %0d status %0d",
                 got.opcode, got.action, got.status_byte);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.opcode !== want.opcode || got.action !== want.action ||
          got.lba !== want.lba || got.block_count !== want.block_count ||
          got.transfer_length !== want.transfer_length ||
          got.status_byte !== want.status_byte) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp op %h act %0d lba %h cnt %0d len %0d sts %0d",
                    " / got op %h act %0d lba %h cnt %0d len %0d sts %0d"},
                   want.opcode, want.action, want.lba, want.block_count,
                   want.transfer_length, want.status_byte,
                   got.opcode, got.action, got.lba, got.block_count,
                   got.transfer_length, got.status_byte);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  cdb_scoreboard sb;
  bit            idle_on;
  int unsigned   hold_req;
  int unsigned   hold_left;
  int unsigned   cycles;
  int unsigned   sent;
  int unsigned   cfg_writes;
  logic [7:0]    known_ops [14];

  scsi_target_cdb_decoder_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_result(out_item);
      if (push && !full) sb.note_request(in_item);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
      pop <= 1'b0;
    end else begin
      pop <= !(idle_on && $urandom_range(99) < 16);
    end
  end

  // called and returns at a falling edge; push stays high for the next request
  task automatic send(input logic [1:0] cmd, input logic [7:0] data);
    while (idle_on && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= {cmd, data};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_TARGET_ID) sb.target_id = value[2:0];
    else sb.medium_present = value[0];
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // one CDB, well formed or cut short, or a single random event
  task automatic run_sequence();
    int unsigned r;
    int unsigned len;
    int unsigned stop;
    logic [7:0]  op;
    r = $urandom_range(99);
    if (r < 10) begin
      send(2'($urandom_range(3)), 8'($urandom));
      return;
    end
    send(CMD_SELECT, 8'($urandom) | (8'd1 << sb.target_id));
    if ($urandom_range(19) == 0)
      send(CMD_SELECT, 8'($urandom) | (8'd1 << sb.target_id));
    op  = ($urandom_range(99) < 85) ? known_ops[$urandom_range(13)] : 8'($urandom);
    len = cdb_scoreboard::len_of(op);
    if (len == 0) len = 1;
    stop = (r < 20) ? $urandom_range(len - 1) : len;
    if (stop == 0 && r < 20) stop = 1;
    send(CMD_BYTE, op);
    for (int i = 1; i < stop; i++) begin
      if (op == OP_INQUIRY && i == 4)
        send(CMD_BYTE, 8'($urandom_range(INQUIRY_MAX_DEF + 8)));
      else
        send(CMD_BYTE, rand_byte());
    end
    if (r < 20 && stop < len) begin
      if ($urandom_range(1) == 0) send(CMD_RESET, rand_byte());
      else send(CMD_SELECT, 8'($urandom) | (8'd1 << sb.target_id));
    end
  endtask

  initial begin
    logic [2:0] tid;
    logic       med;
    sb        = new();
    known_ops = '{OP_TEST_UNIT_READY, OP_REQUEST_SENSE, OP_FORMAT_UNIT, OP_READ6,
                  OP_WRITE6, OP_INQUIRY, OP_MODE_SELECT, OP_MODE_SENSE,
                  OP_START_STOP, OP_READ_CAPACITY, OP_READ10, OP_WRITE10,
                  OP_VERIFY10, OP_READ_BUFFER};
    rst_n    = 1'b0;
    push     = 1'b0;
    in_item  = '0;
    pop      = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_on  = 1'b1;
    hold_req = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    send(CMD_BYTE, 8'hff);
    send(CMD_SELECT, 8'hbf);
    send(CMD_UNUSED, 8'hff);
    send(CMD_BYTE, 8'h00);
    send(CMD_SELECT, 8'h40);
    send(CMD_BYTE, 8'hff);
    send(CMD_SELECT, 8'hff);
    send(CMD_BYTE, OP_READ6);
    send(CMD_BYTE, 8'hff);
    send(CMD_BYTE, 8'hff);
    send(CMD_BYTE, 8'hff);
    send(CMD_BYTE, 8'h00);
    send(CMD_BYTE, 8'h00);
    send(CMD_SELECT, 8'h40);
    send(CMD_BYTE, OP_READ10);
    send(CMD_BYTE, 8'hff);
    send(CMD_RESET, 8'h00);
    send(CMD_BYTE, OP_INQUIRY);
    send(CMD_SELECT, 8'hff);
    send(CMD_SELECT, 8'h40);
    send(CMD_BYTE, OP_INQUIRY);
    for (int i = 1; i < 6; i++) send(CMD_BYTE, (i == 4) ? 8'hff : 8'h00);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tid = 3'd0; med = 1'b1; end
        1: begin tid = 3'd7; med = 1'b0; end
        2: begin tid = 3'd7; med = 1'b1; end
        3: begin tid = 3'd6; med = 1'b1; end
        default: begin tid = 3'($urandom); med = 1'($urandom); end
      endcase
      write_reg(REG_TARGET_ID, {29'd0, tid});
      write_reg(REG_MEDIUM, {31'd0, med});
      idle_on = (p != 2);
      if (p == 1) hold_req = 300;
      for (int n = 0; n < PHASE_ITEMS; ) begin
        int unsigned before_cnt;
        before_cnt = sent;
        run_sequence();
        n += sent - before_cnt;
      end
      drain();
    end
    idle_on = 1'b1;
    repeat (10) @(negedge clk);

    $display("%0d requests sent, %0d results checked, %0d register writes",
             sent, sb.checked, cfg_writes);
    $display("all opcodes, rejected bytes, cut-short CDBs and bus resets, %0d settings",
             PHASES + 1);
    if (sb.pending.size() != 0)
      $display("%0d results never arrived", sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
